FILE: src/m3si_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants and the queue entry type of the 3x3 inverse unit
// no dependencies
package m3si_pkg;

  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NELEM     = 9;
  localparam int unsigned SHIFT     = 2 * FRAC_BITS;
  localparam int unsigned PROD_W    = 2 * ELEM_W;
  localparam int unsigned COF_W     = PROD_W + 1;
  localparam int unsigned PART_W    = 2 * ELEM_W + 1;
  localparam int unsigned TERM_W    = COF_W + ELEM_W;
  localparam int unsigned DET_W     = TERM_W + 2;
  localparam int unsigned MAG_W     = PROD_W;
  localparam int unsigned NUM_W     = MAG_W + SHIFT;
  localparam int unsigned DEN_W     = NUM_W;
  localparam int unsigned QB        = ELEM_W + 1;
  localparam int unsigned DIV_W     = NUM_W + QB + 1;
  localparam int unsigned DETM_W    = DET_W - SHIFT;
  localparam int unsigned QDEPTH    = 8;
  localparam int unsigned QPTR_W    = 3;
  localparam int unsigned QCNT_W    = 4;

  typedef struct packed {
    logic [NELEM-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]            den;
    logic [NELEM-1:0]            neg;
    logic                        sing;
    logic                        det_neg;
    logic [DETM_W-1:0]           det_m;
  } qent_t;

endpackage

FILE: src/m3si_front.sv
`timescale 1ns / 1ps
// front end: cofactors, determinant and classification into divider operands
// depends on m3si_pkg
module m3si_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [m3si_pkg::NELEM-1:0][m3si_pkg::ELEM_W-1:0] in_data_i,
  output logic                                 in_ready_o,
  input  logic                                 pop_i,
  output logic                                 push_o,
  output m3si_pkg::qent_t                      push_data_o
);
  import m3si_pkg::*;

  logic                 acc;
  logic [QCNT_W-1:0]    cnt_q, cnt_d;
  logic [5:0]           v_q;

  logic signed [ELEM_W-1:0] a [NELEM];
  logic signed [PROD_W-1:0] pp_q [NELEM][2];
  logic signed [ELEM_W-1:0] a1_q [3], a2_q [3];
  logic signed [COF_W-1:0]  c2_q [NELEM], c3_q [NELEM], c4_q [NELEM], c5_q [NELEM];
  logic signed [PART_W-1:0] lo_q [3], hi_q [3];
  logic signed [TERM_W-1:0] t_q [3];
  logic signed [DET_W-1:0]  det_q;
  logic [DET_W-1:0]         det_abs;
  qent_t                    ent_d, ent_q;

  // credits cover everything between the input and the queue read side
  assign acc        = in_valid_i & in_ready_o;
  assign in_ready_o = cnt_q < QCNT_W'(QDEPTH);
  assign cnt_d      = cnt_q + QCNT_W'(acc) - QCNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      v_q   <= {v_q[4:0], acc};
    end
  end

  always_comb begin
    for (int i = 0; i < NELEM; i++) a[i] = $signed(in_data_i[i]);
  end

  always_ff @(posedge clk_i) begin
    pp_q[0][0] <= a[4] * a[8];  pp_q[0][1] <= a[5] * a[7];
    pp_q[1][0] <= a[2] * a[7];  pp_q[1][1] <= a[1] * a[8];
    pp_q[2][0] <= a[1] * a[5];  pp_q[2][1] <= a[2] * a[4];
    pp_q[3][0] <= a[5] * a[6];  pp_q[3][1] <= a[3] * a[8];
    pp_q[4][0] <= a[0] * a[8];  pp_q[4][1] <= a[2] * a[6];
    pp_q[5][0] <= a[2] * a[3];  pp_q[5][1] <= a[0] * a[5];
    pp_q[6][0] <= a[3] * a[7];  pp_q[6][1] <= a[4] * a[6];
    pp_q[7][0] <= a[1] * a[6];  pp_q[7][1] <= a[0] * a[7];
    pp_q[8][0] <= a[0] * a[4];  pp_q[8][1] <= a[1] * a[3];
    for (int j = 0; j < 3; j++) begin
      a1_q[j] <= a[j];
      a2_q[j] <= a1_q[j];
    end
    for (int k = 0; k < NELEM; k++) begin
      c2_q[k] <= $signed({pp_q[k][0][PROD_W-1], pp_q[k][0]})
               - $signed({pp_q[k][1][PROD_W-1], pp_q[k][1]});
      c3_q[k] <= c2_q[k];
      c4_q[k] <= c3_q[k];
      c5_q[k] <= c4_q[k];
    end
    // first row times its cofactors, each cofactor split into high and low halves
    lo_q[0] <= a2_q[0] * $signed({1'b0, c2_q[0][ELEM_W-1:0]});
    hi_q[0] <= a2_q[0] * $signed(c2_q[0][COF_W-1:ELEM_W]);
    lo_q[1] <= a2_q[1] * $signed({1'b0, c2_q[3][ELEM_W-1:0]});
    hi_q[1] <= a2_q[1] * $signed(c2_q[3][COF_W-1:ELEM_W]);
    lo_q[2] <= a2_q[2] * $signed({1'b0, c2_q[6][ELEM_W-1:0]});
    hi_q[2] <= a2_q[2] * $signed(c2_q[6][COF_W-1:ELEM_W]);
    for (int j = 0; j < 3; j++) begin
      t_q[j] <= $signed({hi_q[j], {ELEM_W{1'b0}}})
              + $signed({{(TERM_W-PART_W){lo_q[j][PART_W-1]}}, lo_q[j]});
    end
    det_q <= $signed({{2{t_q[0][TERM_W-1]}}, t_q[0]})
           + $signed({{2{t_q[1][TERM_W-1]}}, t_q[1]})
           + $signed({{2{t_q[2][TERM_W-1]}}, t_q[2]});
    ent_q <= ent_d;
  end

  always_comb begin
    logic [COF_W-1:0] cabs;
    det_abs       = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
    ent_d.sing    = det_q == '0;
    ent_d.det_neg = det_q[DET_W-1];
    ent_d.det_m   = det_abs[DET_W-1:SHIFT];
    // a zero determinant divides by 2^(2*SHIFT), which scales by one lsb
    ent_d.den     = ent_d.sing ? (DEN_W'(1) << (2 * SHIFT)) : det_abs[DEN_W-1:0];
    for (int k = 0; k < NELEM; k++) begin
      cabs          = c5_q[k][COF_W-1] ? COF_W'(-c5_q[k]) : COF_W'(c5_q[k]);
      ent_d.num[k]  = {cabs[MAG_W-1:0], {SHIFT{1'b0}}};
      ent_d.neg[k]  = c5_q[k][COF_W-1] ^ det_q[DET_W-1];
    end
  end

  assign push_o      = v_q[5];
  assign push_data_o = ent_q;

endmodule

FILE: src/m3si_queue.sv
`timescale 1ns / 1ps
// short queue of divider operands between front and back
// depends on m3si_pkg
module m3si_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  m3si_pkg::qent_t data_i,
  input  logic            pop_i,
  output m3si_pkg::qent_t data_o,
  output logic            empty_o
);
  import m3si_pkg::*;

  qent_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QPTR_W'(1);
      if (pop_i)  rptr_q <= rptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign data_o  = mem_q[rptr_q];
  assign empty_o = cnt_q == '0;

endmodule

FILE: src/m3si_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on m3si_pkg
module m3si_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [m3si_pkg::NUM_W-1:0]    num_i,
  input  logic [m3si_pkg::DEN_W-1:0]    den_i,
  input  logic                          neg_i,
  output logic [m3si_pkg::QB-1:0]       quo_o,
  output logic                          ovf_o,
  output logic                          neg_o
);
  import m3si_pkg::*;

  logic [NUM_W-1:0] rem_q [QB];
  logic [DEN_W-1:0] den_q [QB];
  logic [QB-1:0]    qt_q  [QB+1];
  logic             ovf_q [QB+1];
  logic             neg_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      qt_q[0]  <= '0;
      // quotient too wide for the stages below always clips
      ovf_q[0] <= DIV_W'(num_i) >= (DIV_W'(den_i) << QB);
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int unsigned Sh = QB - 1 - k;
    logic [DIV_W-1:0] rem_x, sub_x;
    logic             ge;
    assign rem_x = DIV_W'(rem_q[k]);
    assign sub_x = DIV_W'(den_q[k]) << Sh;
    assign ge    = rem_x >= sub_x;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qt_q[k+1]  <= {qt_q[k][QB-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? NUM_W'(rem_x - sub_x) : rem_q[k];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign quo_o = qt_q[QB];
  assign ovf_o = ovf_q[QB];
  assign neg_o = neg_q[QB];

endmodule

FILE: src/m3si_back.sv
`timescale 1ns / 1ps
// back end: nine dividers, saturation and the output register
// depends on m3si_pkg and m3si_div
module m3si_back (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            empty_i,
  input  m3si_pkg::qent_t                                 head_i,
  output logic                                            pop_o,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [m3si_pkg::NELEM:0][m3si_pkg::ELEM_W-1:0]  out_data_o,
  output logic [1:0]                                      out_flags_o
);
  import m3si_pkg::*;

  typedef struct packed {
    logic              sing;
    logic              det_neg;
    logic [DETM_W-1:0] det_m;
  } side_t;

  logic              en;
  logic [QB:0]       v_q;
  side_t             sb_q [QB+1];
  logic              out_valid_q;
  logic [QB-1:0]     quo  [NELEM];
  logic              ovf  [NELEM];
  logic              qneg [NELEM];
  logic [NELEM:0][ELEM_W-1:0] res_d, res_q;
  logic              sat_d;
  logic [1:0]        flags_q;

  function automatic logic [ELEM_W:0] clip_q(input logic [QB-1:0] mag, input logic o,
                                             input logic n);
    logic s;
    logic [ELEM_W-1:0] v;
    if (n) s = o | (mag > (QB'(1) << (ELEM_W - 1)));
    else   s = o | (mag >= (QB'(1) << (ELEM_W - 1)));
    if (s) v = n ? (ELEM_W'(1) << (ELEM_W - 1)) : ~(ELEM_W'(1) << (ELEM_W - 1));
    else   v = n ? ELEM_W'(-mag) : mag[ELEM_W-1:0];
    return {s, v};
  endfunction

  function automatic logic [ELEM_W:0] clip_d(input logic [DETM_W-1:0] mag, input logic n);
    logic s;
    logic [ELEM_W-1:0] v;
    if (n) s = mag > (DETM_W'(1) << (ELEM_W - 1));
    else   s = mag >= (DETM_W'(1) << (ELEM_W - 1));
    if (s) v = n ? (ELEM_W'(1) << (ELEM_W - 1)) : ~(ELEM_W'(1) << (ELEM_W - 1));
    else   v = n ? ELEM_W'(-mag) : mag[ELEM_W-1:0];
    return {s, v};
  endfunction

  // the whole back pipeline holds while a result waits at the output
  assign en    = ~out_valid_q | out_ready_i;
  assign pop_o = en & ~empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[QB-1:0], pop_o};
      out_valid_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= '{sing: head_i.sing, det_neg: head_i.det_neg, det_m: head_i.det_m};
      for (int k = 0; k < QB; k++) sb_q[k+1] <= sb_q[k];
    end
  end

  for (genvar e = 0; e < NELEM; e++) begin : g_div
    m3si_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (head_i.num[e]),
      .den_i (head_i.den),
      .neg_i (head_i.neg[e]),
      .quo_o (quo[e]),
      .ovf_o (ovf[e]),
      .neg_o (qneg[e])
    );
  end

  always_comb begin
    logic [ELEM_W:0] r;
    sat_d = 1'b0;
    for (int e = 0; e < NELEM; e++) begin
      r        = clip_q(quo[e], ovf[e], qneg[e]);
      res_d[e] = r[ELEM_W-1:0];
      sat_d    = sat_d | r[ELEM_W];
    end
    r            = clip_d(sb_q[QB].det_m, sb_q[QB].det_neg);
    res_d[NELEM] = r[ELEM_W-1:0];
    sat_d        = sat_d | r[ELEM_W];
  end

  always_ff @(posedge clk_i) begin
    if (en && v_q[QB]) begin
      res_q   <= res_d;
      flags_q <= {sat_d, sb_q[QB].sing};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;
  assign out_flags_o = flags_q;

endmodule

FILE: src/matrix3_safe_inverse_unit.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate over determinant, signed q16.16 in and out
// top level; depends on m3si_pkg, m3si_front, m3si_queue, m3si_back
//
// usage:
//   s_axis carries one matrix per beat, nine 32-bit elements row by row.
//   m_axis carries one result per beat: the nine inverse elements, then the
//   determinant, all saturated q16.16; tuser holds the singular and
//   saturated flags. a zero determinant scales the cofactors by one lsb.
//   from input beat to output valid the path runs through 6 front stages
//   (products, cofactors, row partials, terms, determinant, magnitudes),
//   the queue, 34 divider stages and the output register.
//   throughput is one matrix per cycle unless m_axis stalls; the dividers
//   resolve one quotient bit per stage, and each element has its own divider.
//   when m_axis stalls the back pipeline holds as a whole, while the front
//   keeps taking beats until 8 matrices sit between input and queue head;
//   then s_axis_tready drops.
//   reset clears all valid bits, queue pointers and credits; no results
//   are pending afterwards and s_axis_tready is high.
module matrix3_safe_inverse_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,  // a00 a01 a02 a10 a11 a12 a20 a21 a22
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [319:0] m_axis_tdata,  // b00 b01 b02 b10 b11 b12 b20 b21 b22 det_value
  output logic [1:0]   m_axis_tuser   // singular saturated
);
  import m3si_pkg::*;

  logic                           push, pop, empty;
  qent_t                          push_data, head;
  logic [NELEM-1:0][ELEM_W-1:0]   in_data;
  logic [NELEM:0][ELEM_W-1:0]     out_data;

  assign in_data = s_axis_tdata;

  m3si_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (in_data),
    .in_ready_o  (s_axis_tready),
    .pop_i       (pop),
    .push_o      (push),
    .push_data_o (push_data)
  );

  m3si_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty)
  );

  m3si_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data),
    .out_flags_o (m_axis_tuser)
  );

  assign m_axis_tdata = out_data;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of matrix3_safe_inverse_unit: random and directed matrices,
// inverses predicted exactly with wide signed arithmetic; depends on m3si_pkg and the rtl
module tb_top;
  import m3si_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [31:0] elem [10];
    logic        sing;
    logic        sat;
  } inv_result_t;

  class inverse_scoreboard;
    inv_result_t pending_q[$];
    int          errors;
    int          checked;
    int          singular_seen;
    int          saturated_seen;

    function automatic logic [31:0] clip32(wide_t v, ref logic sat);
      if (v > wide_t'(32'sh7fffffff)) begin
        sat = 1'b1;
        return 32'h7fffffff;
      end else if (v < -(wide_t'(1) <<< 31)) begin
        sat = 1'b1;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    function automatic void note_matrix(logic [287:0] data);
      wide_t       a [9];
      wide_t       cof [9];
      wide_t       det;
      wide_t       q;
      wide_t       lsb_scale;
      inv_result_t r;
      logic        sat;
      sat = 1'b0;
      lsb_scale = wide_t'(1) <<< SHIFT;
      for (int k = 0; k < 9; k++) a[k] = wide_t'($signed(data[32*k +: 32]));
      cof[0] = a[4] * a[8] - a[5] * a[7];
      cof[1] = a[2] * a[7] - a[1] * a[8];
      cof[2] = a[1] * a[5] - a[2] * a[4];
      cof[3] = a[5] * a[6] - a[3] * a[8];
      cof[4] = a[0] * a[8] - a[2] * a[6];
      cof[5] = a[2] * a[3] - a[0] * a[5];
      cof[6] = a[3] * a[7] - a[4] * a[6];
      cof[7] = a[1] * a[6] - a[0] * a[7];
      cof[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
      r.sing = (det == 0);
      for (int k = 0; k < 9; k++) begin
        // signed division truncates toward zero
        if (r.sing) q = cof[k] / lsb_scale;
        else q = (cof[k] <<< SHIFT) / det;
        r.elem[k] = clip32(q, sat);
      end
      r.elem[9] = clip32(det / lsb_scale, sat);
      r.sat = sat;
      pending_q.push_back(r);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %h want %h", checked, what, got, want);
    endtask

    task automatic check_result(logic [319:0] data, logic [1:0] user);
      inv_result_t r;
      if (pending_q.size() == 0) begin
        report("unexpected beat", data[31:0], 32'h0);
        return;
      end
      r = pending_q.pop_front();
      for (int k = 0; k < 10; k++)
        if (data[32*k +: 32] !== r.elem[k])
          report(k == 9 ? "det_value" : $sformatf("b%0d%0d", k / 3, k % 3),
                 data[32*k +: 32], r.elem[k]);
      if (user[0] !== r.sing) report("singular", {31'b0, user[0]}, {31'b0, r.sing});
      if (user[1] !== r.sat) report("saturated", {31'b0, user[1]}, {31'b0, r.sat});
      if (r.sing) singular_seen++;
      if (r.sat) saturated_seen++;
      checked++;
    endtask
  endclass

  localparam logic [31:0] ONE  = 32'h00010000;
  localparam logic [31:0] MAXV = 32'h7fffffff;
  localparam logic [31:0] MINV = 32'h80000000;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          HOLD_CYCLES    = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [319:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  inverse_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  int hold_req = 0;

  always #5 clk_i = ~clk_i;

  matrix3_safe_inverse_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  // beats seen on both buses, plus the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_matrix(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (!s_axis_tvalid && sb.pending_q.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stalls, and a long hold-off on request
  initial begin
    int hold_cnt;
    int gap;
    hold_cnt = 0;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (hold_req != 0) begin
        hold_req = 0;
        hold_cnt = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        gap = pick_gap();
        m_axis_tready <= (gap == 0);
      end
    end
  end

  task automatic send_matrix(logic [31:0] m [9], int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    for (int k = 0; k < 9; k++) s_axis_tdata[32*k +: 32] <= m[k];
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // stop offering beats, let the monitor note the last one, then wait for all results
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 32'h00080000) - 32'h00040000;   // within +-4.0
      2: return $urandom_range(0, 32'h400) - 32'h200;             // tiny
      default: return $urandom_range(0, 3) == 0 ? MAXV : MINV;
    endcase
  endfunction

  initial begin
    logic [31:0] m [9];
    int kind;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity, negated identity, zero matrix
    foreach (m[k]) m[k] = (k % 4 == 0) ? ONE : 32'h0;
    send_matrix(m, 0);
    foreach (m[k]) m[k] = (k % 4 == 0) ? -ONE : 32'h0;
    send_matrix(m, 0);
    foreach (m[k]) m[k] = 32'h0;
    send_matrix(m, 0);
    // all extremes: singular with huge cofactors zeroed, then mixes
    foreach (m[k]) m[k] = MAXV;
    send_matrix(m, 0);
    foreach (m[k]) m[k] = MINV;
    send_matrix(m, 1);
    foreach (m[k]) m[k] = (k % 4 == 0) ? MINV : 32'h0;
    send_matrix(m, 0);
    foreach (m[k]) m[k] = (k % 4 == 0) ? MAXV : 32'h0;
    send_matrix(m, 0);
    foreach (m[k]) m[k] = (k % 4 == 0) ? 32'h1 : 32'h0;   // inverse overflows
    send_matrix(m, 0);
    foreach (m[k]) m[k] = (k % 2 == 0) ? MAXV : MINV;
    send_matrix(m, 2);
    foreach (m[k]) m[k] = (k == 0 || k == 4) ? ONE : (k == 8 ? 32'h0 : 32'h0);
    send_matrix(m, 0);                                     // singular, cofactor nonzero
    foreach (m[k]) m[k] = 32'hffffffff;
    send_matrix(m, 0);
    foreach (m[k]) m[k] = (k % 4 == 0) ? 32'h00020000 : 32'h00008000;
    send_matrix(m, 0);
    foreach (m[k]) m[k] = (k == 2 || k == 4 || k == 6) ? MINV : 32'h1;
    send_matrix(m, 0);
    wait_drained();

    for (int n = 0; n < 900; n++) begin
      kind = $urandom_range(0, 9);
      foreach (m[k]) m[k] = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
      if ($urandom_range(0, 7) == 0) begin
        // repeated row gives a zero determinant
        for (int c = 0; c < 3; c++) m[6 + c] = m[c];
      end
      if (n == 300) hold_req = 1;
      if (n == 600) wait_drained();
      send_matrix(m, (n >= 300 && n < 340) ? 0 : pick_gap());
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("%0d matrices sent, %0d results checked (%0d singular, %0d saturated)",
             sent, sb.checked, sb.singular_seen, sb.saturated_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
